// ===== sv/quadrature_move_sequencer_unit_macros.svh =====
// assertion helpers for the quadrature move sequencer
`ifndef QUADRATURE_MOVE_SEQUENCER_UNIT_MACROS_SVH
`define QUADRATURE_MOVE_SEQUENCER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define QMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qms check failed");
`define QMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qms check failed");
`else
`define QMS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define QMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/qms_pkg.sv =====
`default_nettype none

package qms_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [30:0] TARGET_COUNT_RST = 31'd2100;
    localparam logic [7:0]  FORWARD_DUTY_RST = 8'd255;
    localparam logic [7:0]  REVERSE_DUTY_RST = 8'd100;
    localparam logic [15:0] PAUSE_TICKS_RST  = 16'd2000;

    localparam logic [1:0] REG_TARGET_COUNT = 2'd0;
    localparam logic [1:0] REG_FORWARD_DUTY = 2'd1;
    localparam logic [1:0] REG_REVERSE_DUTY = 2'd2;
    localparam logic [1:0] REG_PAUSE_TICKS  = 2'd3;

    localparam logic [1:0] MODE_FWD       = 2'd0;
    localparam logic [1:0] MODE_PAUSE_FWD = 2'd1;
    localparam logic [1:0] MODE_REV       = 2'd2;
    localparam logic [1:0] MODE_PAUSE_REV = 2'd3;

    typedef enum logic [3:0] {
        PH_FWD       = 4'b0001,
        PH_PAUSE_FWD = 4'b0010,
        PH_REV       = 4'b0100,
        PH_PAUSE_REV = 4'b1000
    } phase_t;

    typedef struct packed {
        logic line_a;
        logic line_b;
    } in_t;

    typedef struct packed {
        logic [7:0]        drive_duty;
        logic              drive_forward;
        logic signed [31:0] position;
        logic [1:0]        mode;
        logic              jump_error;
    } out_t;

endpackage

`default_nettype wire

// ===== sv/quadrature_move_sequencer_unit.sv =====
// quadrature move sequencer
// input channel: in_valid / in_stall carry one sample of encoder lines a and b
// per request; output channel: out_valid / out_stall carry one result per
// sample: drive duty, direction, signed position, mode and a double-jump flag.
// a sample accepted at an edge is registered and shows on out_data after
// that edge. throughput is one sample per cycle while in_stall is low,
// limited by the single count step, travel-end compare and pause counter
// between input and result register. in_stall rises only while a result is
// held and out_stall is high; the held result does not change until taken.
// reset clears the line history, count, mode (forward) and pause counter and
// loads the default target, duties and pause length. the first sample after
// reset only loads the line history.
// config writes via cfg_we / cfg_index / cfg_data take effect at once and
// should be made only while the block is idle.
`default_nettype none

`include "quadrature_move_sequencer_unit_macros.svh"

module quadrature_move_sequencer_unit #(
    parameter int COUNT_WIDTH = qms_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire qms_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output qms_pkg::out_t      out_data,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [30:0]   cfg_data
);

    localparam int CW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [CW-1:0] POS_MAX = CW'(64'sh000000007FFFFFFF);
    localparam logic signed [CW-1:0] POS_MIN = CW'(64'shFFFFFFFF80000000);

    logic [30:0] target_count_reg;
    logic [7:0]  forward_duty_reg;
    logic [7:0]  reverse_duty_reg;
    logic [15:0] pause_ticks_reg;

    logic [1:0]                    last_lines_reg, last_lines_next;
    logic                          primed_reg;
    logic signed [COUNT_WIDTH-1:0] count_reg, count_next;
    qms_pkg::phase_t               phase_reg, phase_next;
    logic [15:0]                   pause_left_reg, pause_left_next;
    logic                          out_valid_reg;
    qms_pkg::out_t                 out_data_reg, out_data_next;

    logic       accept;
    logic [1:0] lines;
    logic [1:0] diff;
    logic       up;
    logic       counting;
    logic       jump;
    logic signed [CW:0]   cnt_cmp;
    logic signed [CW:0]   tgt_cmp;
    logic signed [CW-1:0] cnt_wide;
    logic signed [31:0]   pos;
    qms_pkg::phase_t      phase_mid;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg <= qms_pkg::TARGET_COUNT_RST;
            forward_duty_reg <= qms_pkg::FORWARD_DUTY_RST;
            reverse_duty_reg <= qms_pkg::REVERSE_DUTY_RST;
            pause_ticks_reg  <= qms_pkg::PAUSE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qms_pkg::REG_TARGET_COUNT: target_count_reg <= cfg_data;
                qms_pkg::REG_FORWARD_DUTY: forward_duty_reg <= cfg_data[7:0];
                qms_pkg::REG_REVERSE_DUTY: reverse_duty_reg <= cfg_data[7:0];
                qms_pkg::REG_PAUSE_TICKS:  pause_ticks_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // decode and count
    always_comb
    begin
        lines    = {in_data.line_b, in_data.line_a};
        diff     = lines ^ last_lines_reg;
        counting = primed_reg && (phase_reg == qms_pkg::PH_FWD || phase_reg == qms_pkg::PH_REV);
        up = (last_lines_reg == 2'd0 && lines == 2'd2) ||
             (last_lines_reg == 2'd2 && lines == 2'd3) ||
             (last_lines_reg == 2'd3 && lines == 2'd1) ||
             (last_lines_reg == 2'd1 && lines == 2'd0);
        jump            = counting && (diff == 2'd3);
        last_lines_next = lines;
        count_next      = count_reg;
        if (counting && diff != 2'd0 && diff != 2'd3)
        begin
            if (up)
            begin
                if (count_reg != CNT_MAX)
                    count_next = count_reg + COUNT_WIDTH'(1);
            end
            else
            begin
                if (count_reg != CNT_MIN)
                    count_next = count_reg - COUNT_WIDTH'(1);
            end
        end
    end

    // mode sequencer
    always_comb
    begin
        phase_mid       = phase_reg;
        pause_left_next = pause_left_reg;
        case (phase_reg)
            qms_pkg::PH_PAUSE_FWD, qms_pkg::PH_PAUSE_REV:
            begin
                if (pause_left_reg <= 16'd1)
                begin
                    pause_left_next = '0;
                    phase_mid = (phase_reg == qms_pkg::PH_PAUSE_FWD) ?
                                qms_pkg::PH_REV : qms_pkg::PH_FWD;
                end
                else
                    pause_left_next = pause_left_reg - 16'd1;
            end
            default: ;
        endcase

        cnt_cmp    = (CW+1)'(count_next);
        tgt_cmp    = signed'((CW+1)'(target_count_reg));
        phase_next = phase_mid;
        if (phase_mid == qms_pkg::PH_FWD && cnt_cmp >= tgt_cmp)
        begin
            phase_next      = qms_pkg::PH_PAUSE_FWD;
            pause_left_next = pause_ticks_reg;
        end
        else if (phase_mid == qms_pkg::PH_REV && cnt_cmp <= (CW+1)'(0))
        begin
            phase_next      = qms_pkg::PH_PAUSE_REV;
            pause_left_next = pause_ticks_reg;
        end
    end

    // result formatting
    always_comb
    begin
        cnt_wide = CW'(count_next);
        if (cnt_wide > POS_MAX)
            pos = 32'sh7FFFFFFF;
        else if (cnt_wide < POS_MIN)
            pos = 32'sh80000000;
        else
            pos = cnt_wide[31:0];

        out_data_next.position   = pos;
        out_data_next.jump_error = jump;
        case (phase_next)
            qms_pkg::PH_FWD:
            begin
                out_data_next.drive_duty    = forward_duty_reg;
                out_data_next.drive_forward = 1'b1;
                out_data_next.mode          = qms_pkg::MODE_FWD;
            end
            qms_pkg::PH_REV:
            begin
                out_data_next.drive_duty    = reverse_duty_reg;
                out_data_next.drive_forward = 1'b0;
                out_data_next.mode          = qms_pkg::MODE_REV;
            end
            qms_pkg::PH_PAUSE_FWD:
            begin
                out_data_next.drive_duty    = '0;
                out_data_next.drive_forward = 1'b1;
                out_data_next.mode          = qms_pkg::MODE_PAUSE_FWD;
            end
            default:
            begin
                out_data_next.drive_duty    = '0;
                out_data_next.drive_forward = 1'b1;
                out_data_next.mode          = qms_pkg::MODE_PAUSE_REV;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_lines_reg <= '0;
            primed_reg     <= 1'b0;
            count_reg      <= '0;
            phase_reg      <= qms_pkg::PH_FWD;
            pause_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_lines_reg <= last_lines_next;
                primed_reg     <= 1'b1;
                count_reg      <= count_next;
                phase_reg      <= phase_next;
                pause_left_reg <= pause_left_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    `QMS_ASSERT_SAME(a_pause_no_drive, clk, rst_n,
        out_valid_reg && (out_data_reg.mode == qms_pkg::MODE_PAUSE_FWD ||
        out_data_reg.mode == qms_pkg::MODE_PAUSE_REV), out_data_reg.drive_duty == 8'd0)
    `QMS_ASSERT_SAME(a_dir_matches_mode, clk, rst_n, out_valid_reg,
        out_data_reg.drive_forward == (out_data_reg.mode != qms_pkg::MODE_REV))
    `QMS_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_reg)
    `QMS_ASSERT_SAME(a_no_pause_left_in_travel, clk, rst_n,
        phase_reg == qms_pkg::PH_FWD || phase_reg == qms_pkg::PH_REV, pause_left_reg == 16'd0)

endmodule

`default_nettype wire

// ===== tb/quadrature_move_sequencer_unit_tb.sv =====
`default_nettype none

module quadrature_move_sequencer_unit_tb;

    localparam int COUNT_W = qms_pkg::COUNT_WIDTH_DEF;
    localparam longint COUNT_HI = (COUNT_W >= 64) ? 64'sh7FFF_FFFF_FFFF_FFFF
                                                  : ((longint'(1) <<< (COUNT_W - 1)) - 1);
    localparam longint COUNT_LO = -COUNT_HI - 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 200;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    qms_pkg::in_t in_data;
    logic out_valid;
    logic out_stall;
    qms_pkg::out_t out_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [30:0] cfg_data;

    quadrature_move_sequencer_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted block state and registers
    logic [30:0] target_count;
    logic [7:0] forward_duty;
    logic [7:0] reverse_duty;
    logic [15:0] pause_ticks;
    logic [1:0] last_lines;
    logic primed;
    longint count;
    logic [1:0] phase;
    logic [15:0] pause_left;

    qms_pkg::out_t expected_results[$];
    logic [1:0] sent_lines;
    int n_samples = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_jumps = 0;
    int n_pause_entries = 0;
    int n_settings = 0;
    int idle_cycles = 0;
    logic [1:0] stall_style = 2'd0;
    logic [6:0] stall_left = '0;

    function automatic logic [1:0] step_up(input logic [1:0] s);
        case (s)
            2'd0: return 2'd2;
            2'd2: return 2'd3;
            2'd3: return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] step_down(input logic [1:0] s);
        case (s)
            2'd2: return 2'd0;
            2'd3: return 2'd2;
            2'd1: return 2'd3;
            default: return 2'd1;
        endcase
    endfunction

    function automatic qms_pkg::out_t predict_sample(input logic [1:0] lines);
        qms_pkg::out_t res;
        logic jump;
        logic [1:0] diff;
        jump = 1'b0;
        diff = lines ^ last_lines;
        if (!primed)
        begin
            primed = 1'b1;
        end
        else if ((phase == qms_pkg::MODE_FWD || phase == qms_pkg::MODE_REV) && diff != 2'd0)
        begin
            if (diff == 2'd3)
            begin
                jump = 1'b1;
                n_jumps++;
            end
            else if (lines == step_up(last_lines))
            begin
                if (count < COUNT_HI)
                    count++;
            end
            else if (count > COUNT_LO)
            begin
                count--;
            end
        end
        last_lines = lines;

        if (phase == qms_pkg::MODE_PAUSE_FWD || phase == qms_pkg::MODE_PAUSE_REV)
        begin
            if (pause_left <= 16'd1)
            begin
                pause_left = '0;
                phase = phase + 2'd1;
            end
            else
            begin
                pause_left--;
            end
        end
        if (phase == qms_pkg::MODE_FWD && count >= longint'(target_count))
        begin
            phase = qms_pkg::MODE_PAUSE_FWD;
            pause_left = pause_ticks;
            n_pause_entries++;
        end
        else if (phase == qms_pkg::MODE_REV && count <= 0)
        begin
            phase = qms_pkg::MODE_PAUSE_REV;
            pause_left = pause_ticks;
            n_pause_entries++;
        end

        res.drive_duty = (phase == qms_pkg::MODE_FWD) ? forward_duty :
                         (phase == qms_pkg::MODE_REV) ? reverse_duty : 8'd0;
        res.drive_forward = (phase != qms_pkg::MODE_REV);
        if (count > longint'(32'sh7FFF_FFFF))
            res.position = 32'sh7FFF_FFFF;
        else if (count < -longint'(32'sh7FFF_FFFF) - 1)
            res.position = 32'sh8000_0000;
        else
            res.position = count[31:0];
        res.mode = phase;
        res.jump_error = jump;
        return res;
    endfunction

    task automatic send_lines(input logic [1:0] lines);
        qms_pkg::in_t item;
        item.line_a = lines[0];
        item.line_b = lines[1];
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_sample(lines));
        sent_lines = lines;
        n_samples++;
    endtask

    task automatic hold_off(input int cycles);
        if (in_valid)
            in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic configure(input logic [30:0] target, input logic [7:0] fwd,
                             input logic [7:0] rev, input logic [15:0] pause);
        logic [30:0] values[4];
        logic [1:0] regs[4];
        values = '{target, {23'd0, fwd}, {23'd0, rev}, {15'd0, pause}};
        regs = '{qms_pkg::REG_TARGET_COUNT, qms_pkg::REG_FORWARD_DUTY,
                 qms_pkg::REG_REVERSE_DUTY, qms_pkg::REG_PAUSE_TICKS};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= values[i];
            @(posedge clk);
            case (regs[i])
                qms_pkg::REG_TARGET_COUNT: target_count = values[i];
                qms_pkg::REG_FORWARD_DUTY: forward_duty = values[i][7:0];
                qms_pkg::REG_REVERSE_DUTY: reverse_duty = values[i][7:0];
                default:                   pause_ticks = values[i][15:0];
            endcase
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [1:0] next_random_lines();
        int r;
        logic toward_up;
        r = $urandom_range(0, 99);
        if (r < 6)
            return sent_lines ^ 2'd3;
        if (r < 16)
            return sent_lines;
        if (phase == qms_pkg::MODE_FWD)
            toward_up = 1'b1;
        else if (phase == qms_pkg::MODE_REV)
            toward_up = 1'b0;
        else
            toward_up = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 20)
            toward_up = !toward_up;
        return toward_up ? step_up(sent_lines) : step_down(sent_lines);
    endfunction

    // first sample, steps both ways, holds and double jumps at the reset settings
    task automatic test_line_decode();
        logic [1:0] seq[12];
        seq = '{2'd3, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd3};
        foreach (seq[i])
            send_lines(seq[i]);
        wait_drained();
    endtask

    // widest target and pause, then zero target and pause
    task automatic test_travel_extremes();
        configure(31'h7FFF_FFFF, 8'd0, 8'hFF, 16'hFFFF);
        send_lines(step_up(sent_lines));
        send_lines(step_up(sent_lines));
        send_lines(step_down(sent_lines));
        send_lines(sent_lines ^ 2'd3);
        wait_drained();
        configure(31'd0, 8'hFF, 8'd0, 16'd0);
        repeat (3)
            send_lines(step_up(sent_lines));
        send_lines(step_down(sent_lines));
        send_lines(sent_lines ^ 2'd3);
        send_lines(step_down(sent_lines));
        wait_drained();
    endtask

    task automatic test_random_travel(input int settings, input int per_setting);
        int left;
        int burst;
        for (int p = 0; p < settings; p++)
        begin
            if (p == 0)
                configure(31'd1, 8'hFF, 8'd0, 16'd0);
            else if (p == settings - 1)
                configure(31'd30, 8'd0, 8'hFF, 16'd12);
            else
                configure(31'($urandom_range(2, 24)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 16'($urandom_range(0, 10)));
            left = per_setting;
            while (left > 0)
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && left > 0; k++)
                begin
                    send_lines(next_random_lines());
                    left--;
                    if (p == 2 && left == per_setting / 2)
                        wait_drained();
                end
                if ($urandom_range(0, 3) != 0)
                    hold_off($urandom_range(1, 6));
            end
            wait_drained();
        end
    endtask

    initial
    begin
        target_count = qms_pkg::TARGET_COUNT_RST;
        forward_duty = qms_pkg::FORWARD_DUTY_RST;
        reverse_duty = qms_pkg::REVERSE_DUTY_RST;
        pause_ticks = qms_pkg::PAUSE_TICKS_RST;
        last_lines = 2'd0;
        primed = 1'b0;
        count = 0;
        phase = qms_pkg::MODE_FWD;
        pause_left = '0;
        sent_lines = 2'd0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        out_stall <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= qms_pkg::REG_TARGET_COUNT;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_line_decode();
        test_travel_extremes();
        test_random_travel(6, 95);

        wait_drained();
        repeat (8) @(posedge clk);
        $display("covered %0d encoder samples over %0d register settings, %0d results checked",
                 n_samples, n_settings, n_checked);
        $display("double jumps predicted: %0d, pauses entered: %0d, mismatches: %0d",
                 n_jumps, n_pause_entries, n_errors);
        if (n_errors == 0)
            $display("quadrature_move_sequencer_unit_tb: PASS");
        else
            $display("quadrature_move_sequencer_unit_tb: FAIL");
        $finish;
    end

    // receiver stall: stretches of none, light, heavy and alternating stall
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= 2'($urandom_range(0, 3));
            stall_left <= 7'($urandom_range(16, 80));
        end
        else
        begin
            stall_left <= stall_left - 7'd1;
        end
        case (stall_style)
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= ($urandom_range(0, 99) < 25);
            2'd2: out_stall <= ($urandom_range(0, 99) < 70);
            default: out_stall <= stall_left[0];
        endcase
    end

    task automatic report_mismatch(input string field, input longint want, input longint got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        qms_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                n_errors++;
                $display("%0t: result with no request pending, expected none, got %p",
                         $time, out_data);
            end
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                if (out_data.drive_duty !== want.drive_duty)
                    report_mismatch("drive_duty", want.drive_duty, out_data.drive_duty);
                if (out_data.drive_forward !== want.drive_forward)
                    report_mismatch("drive_forward", want.drive_forward,
                                    out_data.drive_forward);
                if (out_data.position !== want.position)
                    report_mismatch("position", want.position, out_data.position);
                if (out_data.mode !== want.mode)
                    report_mismatch("mode", want.mode, out_data.mode);
                if (out_data.jump_error !== want.jump_error)
                    report_mismatch("jump_error", want.jump_error, out_data.jump_error);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_results.size());
            $display("quadrature_move_sequencer_unit_tb: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
